// ===== hw/rtl/gvn_pkg.sv =====
// Shared types and constants for the grid vertex normal stencil.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gvn_pkg;

    localparam int POS_W      = 24;
    localparam int DIFF_W     = 25;
    localparam int PROD_W     = 50;
    localparam int NRM_W      = 51;
    localparam int OCOL_W     = 10;
    localparam int ROW_W      = 16;
    localparam int CFG_COLS_W = 11;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_COLS_W-1:0] GRID_COLS_RST = CFG_COLS_W'(64);
    localparam logic [ROW_W-1:0]      GRID_ROWS_RST = ROW_W'(64);

    // 1.0 with 16 fraction bits
    localparam logic signed [NRM_W-1:0] NRM_ONE = NRM_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLS = 1'b0,
        CFG_GRID_ROWS = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } vec_t;

    // Stencil differences plus the bookkeeping that travels with them
    typedef struct packed {
        logic signed [DIFF_W-1:0] ax;
        logic signed [DIFF_W-1:0] ay;
        logic signed [DIFF_W-1:0] az;
        logic signed [DIFF_W-1:0] bx;
        logic signed [DIFF_W-1:0] by;
        logic signed [DIFF_W-1:0] bz;
        logic [OCOL_W-1:0]        col;
        logic [ROW_W-1:0]         row_up;
        logic [ROW_W-1:0]         row;
        logic                     border;
        logic                     two_res;
    } gvn_diff_t;

endpackage

// ===== hw/rtl/gvn_pos_if.sv =====
// Vertex position channel: valid/ready plus one grid vertex.
// Depends on gvn_pkg.
`timescale 1ns / 1ps

interface gvn_pos_if import gvn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== hw/rtl/gvn_nrm_if.sv =====
// Normal result channel: valid/ready plus vertex coordinates and normal.
// Depends on gvn_pkg.
`timescale 1ns / 1ps

interface gvn_nrm_if import gvn_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OCOL_W-1:0]       out_col;
    logic [ROW_W-1:0]        out_row;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    last_of_item;

    modport source (output valid, output out_col, output out_row, output normal_x,
                    output normal_y, output normal_z, output last_of_item, input ready);
    modport sink   (input valid, input out_col, input out_row, input normal_x,
                    input normal_y, input normal_z, input last_of_item, output ready);
endinterface

// ===== hw/rtl/gvn_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on gvn_pkg.
`timescale 1ns / 1ps

interface gvn_cfg_if import gvn_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/gvn_line_store.sv =====
// One row of vertex positions: single write port, one registered read port
// with write-to-read bypass. Depends on gvn_pkg.
`timescale 1ns / 1ps

module gvn_line_store import gvn_pkg::*;
#(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  vec_t          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output vec_t          rdata
);

    vec_t mem [DEPTH];
    vec_t rd_reg;
    vec_t byp_reg;
    logic hit_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg  <= mem[raddr];
            byp_reg <= wdata;
            hit_reg <= we && (raddr == waddr);
        end
    end

    assign rdata = hit_reg ? byp_reg : rd_reg;

endmodule

// ===== hw/rtl/gvn_cross.sv =====
// Cross product stages: product register, then result register that
// emits one or two results per item. Depends on gvn_pkg, gvn_nrm_if.
`timescale 1ns / 1ps

module gvn_cross import gvn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             a_valid,
    output logic             a_ready,
    input  gvn_diff_t        a_data,
    gvn_nrm_if.source        nrm
);

    // product stage
    logic                     b_valid_reg, b_valid_next;
    logic                     b_ready;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    gvn_diff_t                b_meta_reg;

    // result stage
    logic                     c_valid_reg, c_valid_next;
    logic                     c_ready;
    logic                     c_fire;
    logic                     c_load;
    logic                     c_second;
    logic [OCOL_W-1:0]        c_col_reg;
    logic [ROW_W-1:0]         c_orow_reg, c_orow_next;
    logic [ROW_W-1:0]         c_row_reg;
    logic signed [NRM_W-1:0]  c_nx_reg, c_nx_next;
    logic signed [NRM_W-1:0]  c_ny_reg, c_ny_next;
    logic signed [NRM_W-1:0]  c_nz_reg, c_nz_next;
    logic                     c_last_reg, c_last_next;

    assign c_ready = !c_valid_reg || (nrm.ready && c_last_reg);
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = b_ready;

    assign c_fire   = c_valid_reg && nrm.ready;
    assign c_second = c_fire && !c_last_reg;
    assign c_load   = c_ready && b_valid_reg;

    assign b_valid_next = b_ready ? a_valid : b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (a_valid && b_ready)
        begin
            p1_reg     <= a_data.ay * a_data.bz;
            p2_reg     <= a_data.az * a_data.by;
            p3_reg     <= a_data.az * a_data.bx;
            p4_reg     <= a_data.ax * a_data.bz;
            p5_reg     <= a_data.ax * a_data.by;
            p6_reg     <= a_data.ay * a_data.bx;
            b_meta_reg <= a_data;
        end
    end

    always_comb
    begin
        c_valid_next = c_valid_reg;
        c_orow_next  = c_orow_reg;
        c_nx_next    = c_nx_reg;
        c_ny_next    = c_ny_reg;
        c_nz_next    = c_nz_reg;
        c_last_next  = c_last_reg;
        priority if (c_second)
        begin
            // first of two results went out; now the vertex's own border normal
            c_orow_next = c_row_reg;
            c_nx_next   = '0;
            c_ny_next   = NRM_ONE;
            c_nz_next   = '0;
            c_last_next = 1'b1;
        end
        else if (c_load)
        begin
            c_valid_next = 1'b1;
            c_orow_next  = b_meta_reg.row_up;
            c_last_next  = !b_meta_reg.two_res;
            if (b_meta_reg.border)
            begin
                c_nx_next = '0;
                c_ny_next = NRM_ONE;
                c_nz_next = '0;
            end
            else
            begin
                c_nx_next = NRM_W'(p1_reg) - NRM_W'(p2_reg);
                c_ny_next = NRM_W'(p3_reg) - NRM_W'(p4_reg);
                c_nz_next = NRM_W'(p5_reg) - NRM_W'(p6_reg);
            end
        end
        else if (c_ready)
        begin
            c_valid_next = 1'b0;
        end
        else
        begin
            // output stalled: hold the waiting result
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            c_last_reg  <= 1'b1;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            c_last_reg  <= c_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_orow_reg <= c_orow_next;
        c_nx_reg   <= c_nx_next;
        c_ny_reg   <= c_ny_next;
        c_nz_reg   <= c_nz_next;
        if (c_load)
        begin
            c_col_reg <= b_meta_reg.col;
            c_row_reg <= b_meta_reg.row;
        end
    end

    assign nrm.valid        = c_valid_reg;
    assign nrm.out_col      = c_col_reg;
    assign nrm.out_row      = c_orow_reg;
    assign nrm.normal_x     = c_nx_reg;
    assign nrm.normal_y     = c_ny_reg;
    assign nrm.normal_z     = c_nz_reg;
    assign nrm.last_of_item = c_last_reg;

endmodule

// ===== hw/rtl/grid_vertex_normal_stencil.sv =====
// Grid vertex normal stencil: top level with config, raster counters,
// line stores and difference stage. Depends on gvn_pkg, the gvn_*_if
// interfaces, gvn_line_store and gvn_cross.
//
// Usage: vertices enter on pos in raster order, one item per handshake.
// cfg writes grid_cols (index 0) and grid_rows (index 1); it is always
// ready and should only be written while the block is idle.
// Results leave on nrm. A vertex of row r >= 1 yields the normal of the
// vertex above it; a vertex of the last row yields that normal and then its
// own border normal (last_of_item marks the final one). Row 0 yields none.
// Throughput: one vertex per cycle while nrm.ready is high, except while a
// last-row item emits its two results. The line stores are read one item
// ahead at addresses taken from the column counter, so an item needs no
// read wait. An item passes the difference, product and result registers;
// a last-row item holds the result register until both results are out.
// Stall: if nrm.ready is low the three stages fill and pos.ready drops only
// once the difference register is full and cannot move.
// Reset: counters go to column 0 / row 0, both sizes go to 64. Line store
// contents are not cleared; the first two rows of a frame rewrite them.
`timescale 1ns / 1ps

module grid_vertex_normal_stencil import gvn_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    gvn_pos_if.sink    pos,
    gvn_nrm_if.source  nrm,
    gvn_cfg_if.sink    cfg
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int CNTW = $clog2(MAX_COLS + 1);
    localparam int EW   = (CNTW > CFG_COLS_W) ? CNTW : CFG_COLS_W;

    // configuration
    logic [CFG_COLS_W-1:0] grid_cols_reg, grid_cols_next;
    logic [ROW_W-1:0]      grid_rows_reg, grid_rows_next;
    logic [EW-1:0]         cols_ext;
    logic [EW-1:0]         cols_eff;
    logic [ROW_W-1:0]      rows_eff;

    // raster position of the next vertex
    logic [CW-1:0]         col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  last_col;
    logic                  last_row;
    logic [ROW_W-1:0]      row_up;
    logic                  border;

    logic                  accept;
    vec_t                  pos_vec;
    vec_t                  near_m;   // row-1 at this column
    vec_t                  near_r;   // row-1 at the next column
    vec_t                  far_c;    // row-2 at this column
    vec_t                  left_reg; // row-1 at the previous column

    gvn_diff_t             a_reg, a_next;
    logic                  a_valid_reg, a_valid_next;
    logic                  a_ready;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        grid_cols_next = grid_cols_reg;
        grid_rows_next = grid_rows_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_GRID_COLS: grid_cols_next = cfg.data[CFG_COLS_W-1:0];
                CFG_GRID_ROWS: grid_rows_next = cfg.data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign cols_ext = EW'(grid_cols_reg);

    always_comb
    begin
        priority if (cols_ext < EW'(2))
            cols_eff = EW'(2);
        else if (cols_ext > EW'(MAX_COLS))
            cols_eff = EW'(MAX_COLS);
        else
            cols_eff = cols_ext;
    end

    assign rows_eff = (grid_rows_reg < ROW_W'(2)) ? ROW_W'(2) : grid_rows_reg;

    assign last_col = EW'(col_reg) >= (cols_eff - EW'(1));
    assign last_row = row_reg >= (rows_eff - ROW_W'(1));
    assign row_up   = row_reg - ROW_W'(1);
    // past-the-end positions only arise after a mid-frame size change
    assign border   = (col_reg == '0) || last_col || (row_up == '0)
                      || (row_up >= (rows_eff - ROW_W'(1)));

    assign accept    = pos.valid && pos.ready;
    assign pos.ready = !a_valid_reg || a_ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    assign pos_vec.x = pos.pos_x;
    assign pos_vec.y = pos.pos_y;
    assign pos_vec.z = pos.pos_z;

    // Reads are issued at accept for the column that comes next.
    gvn_line_store #(.DEPTH(MAX_COLS)) u_near_m (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pos_vec),
        .re    (accept),
        .raddr (col_next),
        .rdata (near_m)
    );

    gvn_line_store #(.DEPTH(MAX_COLS)) u_near_r (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (pos_vec),
        .re    (accept),
        .raddr (col_next + CW'(1)),
        .rdata (near_r)
    );

    gvn_line_store #(.DEPTH(MAX_COLS)) u_far (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (near_m),
        .re    (accept),
        .raddr (col_next),
        .rdata (far_c)
    );

    always_comb
    begin
        a_next.ax      = DIFF_W'(pos.pos_x) - DIFF_W'(far_c.x);
        a_next.ay      = DIFF_W'(pos.pos_y) - DIFF_W'(far_c.y);
        a_next.az      = DIFF_W'(pos.pos_z) - DIFF_W'(far_c.z);
        a_next.bx      = DIFF_W'(near_r.x) - DIFF_W'(left_reg.x);
        a_next.by      = DIFF_W'(near_r.y) - DIFF_W'(left_reg.y);
        a_next.bz      = DIFF_W'(near_r.z) - DIFF_W'(left_reg.z);
        a_next.col     = OCOL_W'(col_reg);
        a_next.row_up  = row_up;
        a_next.row     = row_reg;
        a_next.border  = border;
        a_next.two_res = last_row;
    end

    always_comb
    begin
        if (accept)
            a_valid_next = (row_reg != '0);
        else if (a_ready)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_COLS_RST;
            grid_rows_reg <= GRID_ROWS_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            grid_cols_reg <= grid_cols_next;
            grid_rows_reg <= grid_rows_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            a_valid_reg   <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= a_next;
            left_reg <= near_m;
        end
    end

    gvn_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_valid (a_valid_reg),
        .a_ready (a_ready),
        .a_data  (a_reg),
        .nrm     (nrm)
    );

`ifndef SYNTH
    a_row0_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (row_reg == '0)) |=> !a_valid_reg)
        else $error("row 0 vertex entered the difference stage");

    a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_col) |=> (col_reg == '0))
        else $error("column counter did not wrap after last column");

    a_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_ready) |=> (a_valid_reg && $stable(a_reg)))
        else $error("stalled difference stage changed");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pos.ready |-> a_valid_reg)
        else $error("input stalled with empty difference stage");
`endif

endmodule
